// ----- design/moving_sum_lowpass_delayed_core_macros.svh -----
// Assertion helpers used by the top-level core design file.
`ifndef MOVING_SUM_LOWPASS_DELAYED_CORE_MACROS_SVH
`define MOVING_SUM_LOWPASS_DELAYED_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MSLD_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MSLD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/msld_pkg.sv -----
`default_nettype none

package msld_pkg;

    localparam int SCALE_SHIFT = 4;

    typedef struct packed {
        logic adv;
        logic clr;
    } msld_ctrl_t;

endpackage

`default_nettype wire

// ----- design/msld_cell.sv -----
`default_nettype none

module msld_cell
    import msld_pkg::*;
#(
    parameter int W = 16
) (
    input  wire logic         aclk,
    input  wire msld_ctrl_t   ctrl,
    input  wire logic [W-1:0] d,
    output logic      [W-1:0] q
);

    logic [W-1:0] q_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.adv) begin
            q_reg <= ctrl.clr ? '0 : d;
        end
    end

    assign q = q_reg;

endmodule

`default_nettype wire

// ----- design/msld_window.sv -----
`default_nettype none

module msld_window
    import msld_pkg::*;
#(
    parameter int WINDOW      = 16,
    parameter int SAMPLE_BITS = 16,
    parameter int SUM_W       = 21
) (
    input  wire logic                          aclk,
    input  wire msld_ctrl_t                    ctrl,
    input  wire logic signed [SAMPLE_BITS-1:0] sample,
    output logic signed      [SUM_W-1:0]       sum_next
);

    logic [SAMPLE_BITS-1:0] tap [WINDOW];
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] base;
    logic signed [SUM_W-1:0] oldest;
    msld_ctrl_t head_ctrl;

    assign head_ctrl = '{adv: ctrl.adv, clr: 1'b0};

    for (genvar i = 0; i < WINDOW; i++) begin : g_tap
        if (i == 0) begin : g_head
            msld_cell #(.W(SAMPLE_BITS)) u_cell (
                .aclk (aclk),
                .ctrl (head_ctrl),
                .d    (sample),
                .q    (tap[i])
            );
        end else begin : g_body
            msld_cell #(.W(SAMPLE_BITS)) u_cell (
                .aclk (aclk),
                .ctrl (ctrl),
                .d    (tap[i-1]),
                .q    (tap[i])
            );
        end
    end

    // A new record starts from an empty window, so the oldest sample reads as zero.
    always_comb begin
        base     = ctrl.clr ? '0 : sum_reg;
        oldest   = ctrl.clr ? '0 : SUM_W'($signed(tap[WINDOW-1]));
        sum_next = base + SUM_W'(sample) - oldest;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.adv) begin
            sum_reg <= sum_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/msld_delay.sv -----
`default_nettype none

module msld_delay
    import msld_pkg::*;
#(
    parameter int DEPTH = 8,
    parameter int W     = 16
) (
    input  wire logic         aclk,
    input  wire logic         adv,
    input  wire logic [W-1:0] d,
    output logic      [W-1:0] q
);

    logic [W-1:0] tap [DEPTH];
    msld_ctrl_t   cell_ctrl;

    assign cell_ctrl = '{adv: adv, clr: 1'b0};

    for (genvar i = 0; i < DEPTH; i++) begin : g_tap
        if (i == 0) begin : g_head
            msld_cell #(.W(W)) u_cell (
                .aclk (aclk),
                .ctrl (cell_ctrl),
                .d    (d),
                .q    (tap[i])
            );
        end else begin : g_body
            msld_cell #(.W(W)) u_cell (
                .aclk (aclk),
                .ctrl (cell_ctrl),
                .d    (tap[i-1]),
                .q    (tap[i])
            );
        end
    end

    assign q = tap[DEPTH-1];

endmodule

`default_nettype wire

// ----- design/moving_sum_lowpass_delayed_core.sv -----
// Channel   Direction  Payload
// s_        in         tdata: sample; tuser: first
// m_        out        tdata: filtered
//
// One request is taken every cycle unless the m_ side stalls; its result appears
// in the output register on the following cycle. The rate is set by the running-sum
// update over the window cell chain. s_tready is high whenever the output register is
// empty or being emptied, so a stalled m_ side holds one result and stops input.
// Reset is synchronous and active low; the first request after reset starts a record.
`default_nettype none

`include "moving_sum_lowpass_delayed_core_macros.svh"

module moving_sum_lowpass_delayed_core
    import msld_pkg::*;
#(
    parameter int WINDOW       = 16,
    parameter int OUTPUT_DELAY = 8,
    parameter int SAMPLE_BITS  = 16,
    localparam int TDATA_W     = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [TDATA_W-1:0] s_tdata,   // sample
    input  wire logic               s_tuser,   // first
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic      [TDATA_W-1:0] m_tdata    // filtered
);

    localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW) + 1;
    localparam int CNT_W = $clog2(OUTPUT_DELAY + 1);
    localparam logic signed [SUM_W-1:0] SAT_HI =
        SUM_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(OUTPUT_DELAY);

    logic                          accept;
    logic                          clr;
    msld_ctrl_t                    win_ctrl;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic signed [SUM_W-1:0]       sum_next;
    logic signed [SUM_W-1:0]       shifted;
    logic [SAMPLE_BITS-1:0]        scaled;
    logic [SAMPLE_BITS-1:0]        delayed;
    logic [CNT_W-1:0]              cnt_eff;
    logic [SAMPLE_BITS-1:0]        result;

    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              count_next;
    logic [SAMPLE_BITS-1:0]        first_scaled_reg;
    logic [SAMPLE_BITS-1:0]        first_scaled_next;
    logic [SAMPLE_BITS-1:0]        tdata_reg;
    logic [SAMPLE_BITS-1:0]        tdata_next;
    logic                          m_tvalid_reg;
    logic                          m_tvalid_next;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign sample   = s_tdata[SAMPLE_BITS-1:0];

    // The count is zero only straight after reset, which starts a record as well.
    assign clr      = s_tuser || (count_reg == '0);
    assign cnt_eff  = clr ? '0 : count_reg;
    assign win_ctrl = '{adv: accept, clr: clr};

    msld_window #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_W       (SUM_W)
    ) u_window (
        .aclk     (aclk),
        .ctrl     (win_ctrl),
        .sample   (sample),
        .sum_next (sum_next)
    );

    msld_delay #(
        .DEPTH (OUTPUT_DELAY),
        .W     (SAMPLE_BITS)
    ) u_delay (
        .aclk (aclk),
        .adv  (accept),
        .d    (scaled),
        .q    (delayed)
    );

    always_comb begin
        shifted = sum_next >>> SCALE_SHIFT;
        if (shifted > SAT_HI) begin
            scaled = SAT_HI[SAMPLE_BITS-1:0];
        end else if (shifted < SAT_LO) begin
            scaled = SAT_LO[SAMPLE_BITS-1:0];
        end else begin
            scaled = shifted[SAMPLE_BITS-1:0];
        end

        if (cnt_eff == '0) begin
            result = scaled;
        end else if (cnt_eff < CNT_FULL) begin
            result = first_scaled_reg;
        end else begin
            result = delayed;
        end
    end

    always_comb begin
        count_next        = count_reg;
        first_scaled_next = first_scaled_reg;
        tdata_next        = tdata_reg;
        m_tvalid_next     = m_tvalid_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (accept) begin
            count_next    = (cnt_eff < CNT_FULL) ? cnt_eff + CNT_W'(1) : cnt_eff;
            tdata_next    = result;
            m_tvalid_next = 1'b1;
            if (cnt_eff == '0) begin
                first_scaled_next = scaled;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        first_scaled_reg <= first_scaled_next;
        tdata_reg        <= tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = TDATA_W'(tdata_reg);

    `MSLD_ASSERT_NEXT(a_accept_gives_result, aclk, aresetn,
        accept, m_tvalid_reg, "accepted request produced no result")
    `MSLD_ASSERT_NOW(a_count_bounded, aclk, aresetn,
        1'b1, count_reg <= CNT_FULL, "sample count passed its limit")
    `MSLD_ASSERT_NEXT(a_first_restarts_count, aclk, aresetn,
        accept && s_tuser, count_reg == CNT_W'(1), "record start did not restart the count")
    `MSLD_ASSERT_NOW(a_ready_when_empty, aclk, aresetn,
        !m_tvalid_reg, s_tready, "input stalled with an empty output register")

endmodule

`default_nettype wire

// ----- dv/moving_sum_lowpass_delayed_core_test.sv -----
`timescale 1ns / 100ps

module moving_sum_lowpass_delayed_core_test;

    localparam int TAPS        = 16;
    localparam int LAG         = 8;
    localparam int SHIFT       = 4;
    localparam int IDLE_LIMIT  = 1000;
    localparam int ITEM_TARGET = 1750;
    localparam int MAX_REPORTS = 10;

    // Predicts the filter output for each accepted request and checks results in order.
    class filter_scoreboard;
        logic signed [15:0] window_taps [TAPS];
        logic signed [20:0] window_total;
        logic signed [15:0] delay_taps [LAG];
        logic signed [15:0] record_head;
        int unsigned        tap_pos;
        int unsigned        delay_pos;
        int unsigned        fill_count;
        logic [15:0]        filtered_due [$];
        int                 fault_count;

        function new();
            clear_history();
            fault_count = 0;
        endfunction

        function void clear_history();
            foreach (window_taps[i]) window_taps[i] = '0;
            foreach (delay_taps[i]) delay_taps[i] = '0;
            window_total = '0;
            record_head  = '0;
            tap_pos      = 0;
            delay_pos    = 0;
            fill_count   = 0;
        endfunction

        function void note_request(logic [15:0] sample, logic first);
            logic signed [15:0] x;
            logic signed [20:0] shifted;
            logic signed [15:0] scaled;
            logic signed [15:0] outcome;
            if (first) clear_history();
            x = sample;
            window_total = window_total + x - window_taps[tap_pos];
            window_taps[tap_pos] = x;
            tap_pos = (tap_pos + 1) % TAPS;
            shifted = window_total >>> SHIFT;
            scaled = shifted[15:0];
            if (fill_count == 0) record_head = scaled;
            outcome = (fill_count < LAG) ? record_head : delay_taps[delay_pos];
            delay_taps[delay_pos] = scaled;
            delay_pos = (delay_pos + 1) % LAG;
            if (fill_count < LAG) fill_count++;
            filtered_due.push_back(outcome);
        endfunction

        function void check_result(logic [15:0] got);
            logic [15:0] want;
            if (filtered_due.size() == 0) begin
                fault_count++;
                if (fault_count <= MAX_REPORTS)
                    $display("Unrequested result: filtered=%0d", $signed(got));
                return;
            end
            want = filtered_due.pop_front();
            if (got !== want) begin
                fault_count++;
                if (fault_count <= MAX_REPORTS)
                    $display("Mismatch on filtered: expected %0d, got %0d",
                             $signed(want), $signed(got));
            end
        endfunction

        function int pending();
            return filtered_due.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;

    logic        steady_in;
    logic        steady_out;
    int          sent;
    filter_scoreboard board = new();

    moving_sum_lowpass_delayed_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) board.note_request(s_tdata, s_tuser);
            if (m_tvalid && m_tready) board.check_result(m_tdata);
        end
    end

    initial begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) idle = 0;
            else idle++;
        end
        $display("moving_sum_lowpass_delayed_core test failed");
        $finish;
    end

    initial begin
        int gap;
        m_tready = 1'b0;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            gap = steady_out ? 0 : $urandom_range(0, 9);
            if (gap != 0) begin
                m_tready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    task automatic send_sample(input logic [15:0] sample, input logic first);
        int gap;
        gap = steady_in ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = sample;
        s_tuser  = first;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        sent++;
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 16'h7fff;
            1:       return 16'h8000;
            2:       return 16'hffff;
            3:       return 16'($signed($urandom_range(0, 64)) - 32);
            default: return 16'($urandom());
        endcase
    endfunction

    initial begin
        int span;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = 1'b0;
        steady_in  = 1'b0;
        steady_out = 1'b0;
        sent       = 0;
        aresetn    = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // The first record after reset starts without the first flag.
        for (int i = 0; i < 9; i++) send_sample(16'h7fff, 1'b0);
        for (int i = 0; i < 9; i++) send_sample(16'h8000, i == 0);
        send_sample(16'hffff, 1'b1);
        send_sample(16'h0001, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'h0010, 1'b1);
        send_sample(16'hffef, 1'b1);
        wait_drained();

        while (sent < ITEM_TARGET) begin
            steady_in  = ($urandom_range(0, 4) == 0);
            steady_out = ($urandom_range(0, 4) == 0);
            span = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 40);
            for (int i = 0; i < span; i++) begin
                if (i == 0) send_sample(pick_sample(), $urandom_range(0, 19) != 0);
                else        send_sample(pick_sample(), $urandom_range(0, 39) == 0);
            end
            if ($urandom_range(0, 19) == 0) wait_drained();
        end
        s_tvalid = 1'b0;

        while (board.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (board.fault_count == 0 && board.pending() == 0) begin
            $display("moving_sum_lowpass_delayed_core test passed");
        end else begin
            $display("moving_sum_lowpass_delayed_core test failed");
        end
        $finish;
    end

endmodule
